/* sv/semct_pkg.sv */
`timescale 1ns / 1ps

package semct_pkg;

	// Default sizes of the table.
	localparam int NUM_SEMS_DEF    = 32;
	localparam int NUM_THREADS_DEF = 32;
	localparam int COUNT_WIDTH_DEF = 32;

	// Operation codes as they arrive on the opcode port.
	typedef enum logic [2:0] {
		OP_ALLOC     = 3'd0,
		OP_FREE      = 3'd1,
		OP_INIT      = 3'd2,
		OP_WAIT      = 3'd3,
		OP_TRYWAIT   = 3'd4,
		OP_TIMEDWAIT = 3'd5,
		OP_POST      = 3'd6
	} op_t;

	// Status codes returned with every result word.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_AGAIN     = 3'd2;
	localparam logic [2:0] ST_BLOCKED   = 3'd3;
	localparam logic [2:0] ST_NONE_FREE = 3'd4;

	// One request word as held in the stage register.
	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  sem_id;
		logic [4:0]  thread_id;
		logic [31:0] init_value;
		logic [31:0] timeout_ms;
		logic [31:0] now_ticks;
	} req_t;

	// One result word as held in the output register.
	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  alloc_id;
		logic        woken_valid;
		logic [4:0]  woken_thread;
		logic        cancel_timeout;
		logic        arm_timer;
		logic [31:0] deadline;
	} rsp_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [4:0] lowest_set(input logic [31:0] v);
		logic [4:0] idx;
		idx = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (v[i]) begin
				idx = 5'(i);
			end
		end
		return idx;
	endfunction

endpackage

/* sv/semct_ram.sv */
`timescale 1ns / 1ps

// Single-port-write, single-port-read table with registered read data.
// Entries read as zero until first written. A write in the same cycle as a
// read of the same entry is forwarded to the read data.
module semct_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [WIDTH-1:0] mem_rd_q;
	logic             rd_written_q;
	logic             fwd_q;
	logic [WIDTH-1:0] fwd_data_q;
	logic             hit;

	assign hit = rd_en && we && (rd_addr == wr_addr);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
			fwd_q        <= 1'b0;
		end else begin
			if (we) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
				fwd_q        <= hit;
			end
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : (rd_written_q ? mem_rd_q : '0);

endmodule

/* sv/counting_semaphore_table_core.sv */
`timescale 1ns / 1ps

// Counting semaphore table. Each request word carries one operation (alloc,
// free, init, wait, trywait, timed wait, post) and produces exactly one result
// word. A new request can be taken in every cycle. A request word is held in
// the stage register, where the counter and waiter tables, read at acceptance,
// are updated, and its result word then moves into the output register, from
// which it is taken. The only thing that slows the block is the output side:
// when a result sits unread in the output register and the stage register is
// also full, req_ready drops.
// Counts and waiter bitmaps live in two small RAMs with per-entry written
// bits, so the block is ready right after reset with no clearing pass. A
// post wakes the lowest-numbered waiting thread; a timed wait that blocks
// asks the external timer to arm at now_ticks + timeout_ms (mod 2^32).
module counting_semaphore_table_core #(
	parameter int NUM_SEMS    = semct_pkg::NUM_SEMS_DEF,
	parameter int NUM_THREADS = semct_pkg::NUM_THREADS_DEF,
	parameter int COUNT_WIDTH = semct_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  opcode,
	input  logic [7:0]  sem_id,
	input  logic [4:0]  thread_id,
	input  logic [31:0] init_value,
	input  logic [31:0] timeout_ms,
	input  logic [31:0] now_ticks,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  status,
	output logic [4:0]  alloc_id,
	output logic        woken_valid,
	output logic [4:0]  woken_thread,
	output logic        cancel_timeout,
	output logic        arm_timer,
	output logic [31:0] deadline
);

	localparam int SAW       = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int TW        = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
	localparam int ALLOC_LIM = (NUM_SEMS < 32) ? NUM_SEMS : 32;
	localparam logic [31:0] CNT_MAX32 = 32'hFFFF_FFFF >> (32 - COUNT_WIDTH);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = CNT_MAX32[COUNT_WIDTH-1:0];

	// Stage register and output register.
	logic               s1_valid_q;
	semct_pkg::req_t    s1_req_s1;
	logic               rsp_valid_q;
	semct_pkg::rsp_t    rsp_q;

	// Table state kept in flip-flops.
	logic [NUM_SEMS-1:0]    alloc_map_q;
	logic [NUM_THREADS-1:0] timed_q;

	logic adv_s1;
	logic accept;

	assign adv_s1    = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q || adv_s1;
	assign accept    = req_valid && req_ready;

	// Count and waiter tables.
	logic                   cnt_we;
	logic [SAW-1:0]         cnt_waddr;
	logic [COUNT_WIDTH-1:0] cnt_wdata;
	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic                   wm_we;
	logic [NUM_THREADS-1:0] wm_wdata;
	logic [NUM_THREADS-1:0] wm_rd;

	semct_ram #(
		.DEPTH (NUM_SEMS),
		.WIDTH (COUNT_WIDTH),
		.AW    (SAW)
	) u_cnt_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (SAW'(sem_id)),
		.we      (cnt_we),
		.wr_addr (cnt_waddr),
		.wr_data (cnt_wdata),
		.rd_data (cnt_rd)
	);

	semct_ram #(
		.DEPTH (NUM_SEMS),
		.WIDTH (NUM_THREADS),
		.AW    (SAW)
	) u_wait_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (SAW'(sem_id)),
		.we      (wm_we),
		.wr_addr (SAW'(s1_req_s1.sem_id)),
		.wr_data (wm_wdata),
		.rd_data (wm_rd)
	);

	// Decode of the word in the stage register.
	semct_pkg::op_t         op;
	logic [SAW-1:0]         sem_addr;
	logic                   sem_ok;
	logic                   th_ok;
	logic                   is_alloc_bit;
	logic [TW-1:0]          th_idx;
	logic [ALLOC_LIM-1:0]   free_v;
	logic [4:0]             free_idx;
	logic                   any_free;
	logic [4:0]             wake_idx;
	logic [TW-1:0]          wake_tidx;
	logic [COUNT_WIDTH-1:0] init_cnt;
	semct_pkg::rsp_t        res;
	logic                   alloc_set;
	logic                   alloc_clr;
	logic                   timed_set;
	logic                   timed_clr;

	assign op           = semct_pkg::op_t'(s1_req_s1.opcode);
	assign sem_addr     = SAW'(s1_req_s1.sem_id);
	assign sem_ok       = 32'(s1_req_s1.sem_id) < 32'(NUM_SEMS);
	assign th_ok        = 32'(s1_req_s1.thread_id) < 32'(NUM_THREADS);
	assign is_alloc_bit = sem_ok && alloc_map_q[sem_addr];
	assign th_idx       = TW'(s1_req_s1.thread_id);
	assign free_v       = ~alloc_map_q[ALLOC_LIM-1:0];
	assign free_idx     = semct_pkg::lowest_set(32'(free_v));
	assign any_free     = |free_v;
	assign wake_idx     = semct_pkg::lowest_set(32'(wm_rd));
	assign wake_tidx    = TW'(wake_idx);
	assign init_cnt     = (s1_req_s1.init_value > CNT_MAX32) ? CNT_MAX
	                    : s1_req_s1.init_value[COUNT_WIDTH-1:0];

	always_comb begin
		res       = '0;
		res.status = semct_pkg::ST_OK;
		cnt_we    = 1'b0;
		cnt_waddr = sem_addr;
		cnt_wdata = init_cnt;
		wm_we     = 1'b0;
		wm_wdata  = wm_rd;
		alloc_set = 1'b0;
		alloc_clr = 1'b0;
		timed_set = 1'b0;
		timed_clr = 1'b0;
		case (op)
			semct_pkg::OP_ALLOC: begin
				if (any_free) begin
					alloc_set    = 1'b1;
					cnt_we       = 1'b1;
					cnt_waddr    = SAW'(free_idx);
					res.alloc_id = free_idx;
				end else begin
					res.status = semct_pkg::ST_NONE_FREE;
				end
			end
			semct_pkg::OP_FREE: begin
				if (sem_ok) begin
					alloc_clr = 1'b1;
				end else begin
					res.status = semct_pkg::ST_INVALID;
				end
			end
			semct_pkg::OP_INIT, semct_pkg::OP_WAIT, semct_pkg::OP_TRYWAIT,
			semct_pkg::OP_TIMEDWAIT, semct_pkg::OP_POST: begin
				if (!is_alloc_bit || (!th_ok && (op == semct_pkg::OP_WAIT ||
				                                 op == semct_pkg::OP_TIMEDWAIT))) begin
					res.status = semct_pkg::ST_INVALID;
				end else if (op == semct_pkg::OP_INIT) begin
					cnt_we = 1'b1;
				end else if (op == semct_pkg::OP_POST) begin
					if (wm_rd == '0) begin
						cnt_wdata = cnt_rd + COUNT_WIDTH'(1);
						cnt_we    = (cnt_rd != CNT_MAX);
					end else begin
						// Release the lowest-numbered waiter instead of counting up.
						wm_we              = 1'b1;
						wm_wdata           = wm_rd & ~(NUM_THREADS'(1) << wake_tidx);
						timed_clr          = 1'b1;
						res.woken_valid    = 1'b1;
						res.woken_thread   = wake_idx;
						res.cancel_timeout = timed_q[wake_tidx];
					end
				end else if (cnt_rd != '0) begin
					cnt_wdata = cnt_rd - COUNT_WIDTH'(1);
					cnt_we    = 1'b1;
				end else if (op == semct_pkg::OP_TRYWAIT) begin
					res.status = semct_pkg::ST_AGAIN;
				end else begin
					// Count is zero: the caller becomes a waiter.
					wm_we      = 1'b1;
					wm_wdata   = wm_rd | (NUM_THREADS'(1) << th_idx);
					res.status = semct_pkg::ST_BLOCKED;
					if (op == semct_pkg::OP_TIMEDWAIT) begin
						timed_set     = 1'b1;
						res.arm_timer = 1'b1;
						res.deadline  = s1_req_s1.now_ticks + s1_req_s1.timeout_ms;
					end
				end
			end
			default: begin
				res.status = semct_pkg::ST_INVALID;
			end
		endcase
		// State changes only when the word moves on to the output register.
		cnt_we = cnt_we && adv_s1;
		wm_we  = wm_we && adv_s1;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_req_s1 <= '{opcode: opcode, sem_id: sem_id, thread_id: thread_id,
			              init_value: init_value, timeout_ms: timeout_ms,
			              now_ticks: now_ticks};
		end
		if (adv_s1) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			alloc_map_q <= '0;
			timed_q     <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (adv_s1) begin
				s1_valid_q <= 1'b0;
			end
			if (adv_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (adv_s1 && alloc_set) begin
				alloc_map_q[SAW'(free_idx)] <= 1'b1;
			end
			if (adv_s1 && alloc_clr) begin
				alloc_map_q[sem_addr] <= 1'b0;
			end
			if (adv_s1 && timed_set) begin
				timed_q[th_idx] <= 1'b1;
			end
			if (adv_s1 && timed_clr) begin
				timed_q[wake_tidx] <= 1'b0;
			end
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = rsp_q.status;
	assign alloc_id       = rsp_q.alloc_id;
	assign woken_valid    = rsp_q.woken_valid;
	assign woken_thread   = rsp_q.woken_thread;
	assign cancel_timeout = rsp_q.cancel_timeout;
	assign arm_timer      = rsp_q.arm_timer;
	assign deadline       = rsp_q.deadline;

	// The request side only stalls behind a full stage and a held result.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (s1_valid_q && rsp_valid_q && !rsp_ready))
		else $error("req_ready low without a stalled output");

	// A successful allocation marks its entry as allocated.
	a_alloc_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && alloc_set) |=> alloc_map_q[$past(SAW'(free_idx))])
		else $error("allocated entry not marked");

	// A timed wait that blocks records its thread as a timed waiter.
	a_timed_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && timed_set) |=> timed_q[$past(th_idx)])
		else $error("timed waiter not recorded");

	// A woken thread no longer has a pending timeout.
	a_wake_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && timed_clr) |=> !timed_q[$past(wake_tidx)])
		else $error("woken thread still marked as timed waiter");

	// Arming the timer always comes with a blocked status on the same result.
	a_arm_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res.arm_timer) |=> (rsp_valid && status == semct_pkg::ST_BLOCKED))
		else $error("timer armed on a result that is not blocked");

endmodule
